@@ rtl/core/rusi_pkg.sv @@
// Shared types, constants and helpers for the unit-sphere ray intersect core.
// No dependencies; every other file in rtl/core uses this package.
package rusi_pkg;

  localparam int QDEPTH_DEF   = 4;     // front-to-back queue entries
  localparam int SQ_WIDE      = 64;    // radicand width of the 64-bit root units
  localparam int SQ_NARROW    = 34;    // radicand width for sqrt(1 - z^2)
  localparam int DIV_NUM      = 48;    // |p_i| << 16, per component
  localparam int DIV_DEN      = 32;    // |p| length
  localparam int CORDIC_STEPS = 17;
  localparam int XW           = 36;    // CORDIC x/y width, covers gain growth
  localparam int ZW           = 21;    // CORDIC angle width

  localparam logic signed [ZW-1:0] PI_Q = 21'sd205887;

  typedef struct packed {
    logic              func;
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    logic signed [31:0] span_low;
    logic signed [31:0] span_high;
  } in_item_t;

  typedef struct packed {
    logic              hit;
    logic signed [31:0] t_param;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [31:0] normal_x;
    logic signed [31:0] normal_y;
    logic signed [31:0] normal_z;
    logic signed [31:0] tex_u;
    logic signed [31:0] tex_v;
  } out_item_t;

  // Classified ray handed from the front part to the back part.
  typedef struct packed {
    logic              hit;
    logic signed [31:0] t;
    logic signed [31:0] o_x;
    logic signed [31:0] o_y;
    logic signed [31:0] o_z;
    logic signed [31:0] d_x;
    logic signed [31:0] d_y;
    logic signed [31:0] d_z;
  } queue_item_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return $signed(v[31:0]);
    end
  endfunction

  // atan(2^-i) in Q16.16, rounded to nearest
  function automatic logic signed [ZW-1:0] atan_q(input int i);
    case (i)
      0:  return 21'sd51472;
      1:  return 21'sd30386;
      2:  return 21'sd16055;
      3:  return 21'sd8150;
      4:  return 21'sd4091;
      5:  return 21'sd2047;
      6:  return 21'sd1024;
      7:  return 21'sd512;
      8:  return 21'sd256;
      9:  return 21'sd128;
      10: return 21'sd64;
      11: return 21'sd32;
      12: return 21'sd16;
      13: return 21'sd8;
      14: return 21'sd4;
      15: return 21'sd2;
      16: return 21'sd1;
      default: return '0;
    endcase
  endfunction

endpackage

@@ rtl/core/ray_unit_sphere_intersect_core.sv @@
// Ray against unit sphere, Q16.16. One item per cycle sustained while out_ready is high.
// The 32-step root units and the 48-step normal divider hold most of the depth.
// The front part and the back part stall separately through a small queue.
// Reset (rst_n, synchronous, active low) clears pipeline valids and queue state.
module ray_unit_sphere_intersect_core #(
  parameter int QUEUE_DEPTH = rusi_pkg::QDEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rusi_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output rusi_pkg::out_item_t out_data
);
  import rusi_pkg::*;

  localparam int AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic        push_valid;
  queue_item_t push_data;
  logic        q_full;
  logic        q_empty;
  logic        q_push;
  logic        q_pop;

  queue_item_t      q_mem_r [QUEUE_DEPTH];
  logic [AW-1:0]    wr_ptr_r;
  logic [AW-1:0]    rd_ptr_r;
  logic [CNT_W-1:0] q_cnt_r;

  rusi_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_data  (push_data),
    .q_full     (q_full)
  );

  assign q_full  = (q_cnt_r == CNT_W'(QUEUE_DEPTH));
  assign q_empty = (q_cnt_r == '0);
  assign q_push  = push_valid && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      q_cnt_r  <= '0;
    end else begin
      if (q_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (q_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (q_push && !q_pop) begin
        q_cnt_r <= q_cnt_r + 1'b1;
      end else if (q_pop && !q_push) begin
        q_cnt_r <= q_cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) begin
      q_mem_r[wr_ptr_r] <= push_data;
    end
  end

  rusi_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (!q_empty),
    .q_data    (q_mem_r[rd_ptr_r]),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_q_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (q_cnt_r != '0))
    else $error("pop from empty queue");

  a_q_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && !q_pop) |=> (q_cnt_r == $past(q_cnt_r) + 1'b1))
    else $error("queue count did not follow push");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.hit) |->
      (out_data.t_param == '0 && out_data.tex_u == '0 && out_data.normal_x == '0))
    else $error("miss item carries nonzero fields");

endmodule

@@ rtl/core/rusi_sqrt.sv @@
// Pipelined integer square root, one result bit per stage, floor(sqrt(rad)).
// Carries a sideband word alongside; no reset (valid tracking lives upstream).
module rusi_sqrt #(
  parameter int W  = rusi_pkg::SQ_WIDE,
  parameter int SW = 1
) (
  input  logic            clk,
  input  logic            en,
  input  logic [W-1:0]    rad_in,
  input  logic [SW-1:0]   side_in,
  output logic [W/2-1:0]  root_out,
  output logic [SW-1:0]   side_out
);

  localparam int ST = W / 2;

  logic [W-1:0]  n_r    [ST];
  logic [W-1:0]  root_r [ST];
  logic [SW-1:0] side_r [ST];
  logic [W-1:0]  n_nxt    [ST];
  logic [W-1:0]  root_nxt [ST];
  logic [W-1:0]  n_src    [ST];
  logic [W-1:0]  root_src [ST];

  always_comb begin
    logic [W-1:0] bitv;
    logic [W-1:0] trial;
    n_src[0]    = rad_in;
    root_src[0] = '0;
    for (int k = 1; k < ST; k++) begin
      n_src[k]    = n_r[k-1];
      root_src[k] = root_r[k-1];
    end
    for (int k = 0; k < ST; k++) begin
      bitv  = {{(W-1){1'b0}}, 1'b1} << (W - 2 - 2*k);
      trial = root_src[k] + bitv;
      if (n_src[k] >= trial) begin
        n_nxt[k]    = n_src[k] - trial;
        root_nxt[k] = (root_src[k] >> 1) + bitv;
      end else begin
        n_nxt[k]    = n_src[k];
        root_nxt[k] = root_src[k] >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_r       <= n_nxt;
      root_r    <= root_nxt;
      side_r[0] <= side_in;
      for (int k = 1; k < ST; k++) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  assign root_out = root_r[ST-1][ST-1:0];
  assign side_out = side_r[ST-1];

endmodule

@@ rtl/core/rusi_div.sv @@
// Pipelined restoring divider, several lanes sharing one divisor, one
// quotient bit per stage. Depends on rusi_pkg for default widths.
module rusi_div #(
  parameter int NW    = rusi_pkg::DIV_NUM,
  parameter int DW    = rusi_pkg::DIV_DEN,
  parameter int LANES = 3,
  parameter int SW    = 1
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic [LANES-1:0][NW-1:0]   num_in,
  input  logic [DW-1:0]              den_in,
  input  logic [SW-1:0]              side_in,
  output logic [LANES-1:0][NW-1:0]   quo_out,
  output logic [SW-1:0]              side_out
);

  // dvd shifts left each step; the quotient bits fill in from the bottom
  logic [LANES-1:0][DW-1:0] rem_r [NW];
  logic [LANES-1:0][NW-1:0] dvd_r [NW];
  logic [DW-1:0]            den_r [NW];
  logic [SW-1:0]            side_r [NW];
  logic [LANES-1:0][DW-1:0] rem_nxt [NW];
  logic [LANES-1:0][NW-1:0] dvd_nxt [NW];
  logic [LANES-1:0][DW-1:0] rem_src [NW];
  logic [LANES-1:0][NW-1:0] dvd_src [NW];
  logic [DW-1:0]            den_src [NW];

  always_comb begin
    logic [DW:0] tmp;
    logic        ge;
    rem_src[0] = '0;
    dvd_src[0] = num_in;
    den_src[0] = den_in;
    for (int k = 1; k < NW; k++) begin
      rem_src[k] = rem_r[k-1];
      dvd_src[k] = dvd_r[k-1];
      den_src[k] = den_r[k-1];
    end
    for (int k = 0; k < NW; k++) begin
      for (int l = 0; l < LANES; l++) begin
        tmp = {rem_src[k][l], dvd_src[k][l][NW-1]};
        ge  = (tmp >= {1'b0, den_src[k]});
        if (ge) begin
          rem_nxt[k][l] = DW'(tmp - {1'b0, den_src[k]});
        end else begin
          rem_nxt[k][l] = tmp[DW-1:0];
        end
        dvd_nxt[k][l] = {dvd_src[k][l][NW-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      dvd_r <= dvd_nxt;
      den_r <= den_src;
      side_r[0] <= side_in;
      for (int k = 1; k < NW; k++) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  assign quo_out  = dvd_r[NW-1];
  assign side_out = side_r[NW-1];

endmodule

@@ rtl/core/rusi_cordic.sv @@
// Pipelined vectoring CORDIC giving atan2(yy, xx) in Q16.16 radians.
// One quadrant-fold stage then one stage per rotation; uses rusi_pkg tables.
module rusi_cordic (
  input  logic                           clk,
  input  logic                           en,
  input  logic signed [31:0]             yy,
  input  logic signed [31:0]             xx,
  output logic signed [rusi_pkg::ZW-1:0] z_out
);
  import rusi_pkg::*;

  localparam int NS = CORDIC_STEPS + 1;

  logic signed [XW-1:0] x_r [NS];
  logic signed [XW-1:0] y_r [NS];
  logic signed [ZW-1:0] z_r [NS];
  logic                 zf_r [NS];
  logic signed [XW-1:0] x_nxt [NS];
  logic signed [XW-1:0] y_nxt [NS];
  logic signed [ZW-1:0] z_nxt [NS];
  logic                 zf_nxt [NS];

  always_comb begin
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    // fold the left half-plane over, starting at +/- pi
    zf_nxt[0] = (xx == '0) && (yy == '0);
    if (xx < 0) begin
      x_nxt[0] = -XW'(xx);
      y_nxt[0] = -XW'(yy);
      z_nxt[0] = (yy >= 0) ? PI_Q : -PI_Q;
    end else begin
      x_nxt[0] = XW'(xx);
      y_nxt[0] = XW'(yy);
      z_nxt[0] = '0;
    end
    for (int i = 1; i < NS; i++) begin
      dx = y_r[i-1] >>> (i - 1);
      dy = x_r[i-1] >>> (i - 1);
      zf_nxt[i] = zf_r[i-1];
      if (y_r[i-1] > 0) begin
        x_nxt[i] = x_r[i-1] + dx;
        y_nxt[i] = y_r[i-1] - dy;
        z_nxt[i] = z_r[i-1] + atan_q(i - 1);
      end else begin
        x_nxt[i] = x_r[i-1] - dx;
        y_nxt[i] = y_r[i-1] + dy;
        z_nxt[i] = z_r[i-1] - atan_q(i - 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r  <= x_nxt;
      y_r  <= y_nxt;
      z_r  <= z_nxt;
      zf_r <= zf_nxt;
    end
  end

  assign z_out = zf_r[NS-1] ? '0 : z_r[NS-1];

endmodule

@@ rtl/core/rusi_front.sv @@
// Front part: dot products, discriminant, root and span test; emits one
// classified item per accepted ray. Uses rusi_pkg and rusi_sqrt.
module rusi_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  rusi_pkg::in_item_t    in_data,
  output logic                  push_valid,
  output rusi_pkg::queue_item_t push_data,
  input  logic                  q_full
);
  import rusi_pkg::*;

  localparam int SQ_LAT = SQ_WIDE / 2;
  localparam int NF     = 3 + SQ_LAT + 1;

  typedef struct packed {
    logic              func;
    logic              neg;
    logic signed [31:0] b;
    logic signed [31:0] o_x;
    logic signed [31:0] o_y;
    logic signed [31:0] o_z;
    logic signed [31:0] d_x;
    logic signed [31:0] d_y;
    logic signed [31:0] d_z;
    logic signed [31:0] lo;
    logic signed [31:0] hi;
  } fside_t;

  logic [NF-1:0] vld_r;
  logic          adv;

  logic signed [31:0] o_v [3];
  logic signed [31:0] d_v [3];
  logic signed [63:0] m_od [3];
  logic signed [63:0] m_oo [3];

  in_item_t           pay1_r;
  logic signed [47:0] pb1_r [3];
  logic signed [47:0] pc1_r [3];
  in_item_t           pay2_r;
  logic signed [31:0] b2_r;
  logic signed [31:0] c2_r;
  fside_t             side3_r;
  logic [63:0]        disc3_r;
  logic signed [63:0] bsum;
  logic signed [63:0] csum;
  logic signed [63:0] disc;

  logic [SQ_LAT-1:0]  s_root;
  fside_t             s_side;
  logic signed [63:0] nb;
  logic signed [63:0] s64;
  logic signed [31:0] t_sel;
  queue_item_t        push_r;

  assign adv      = !vld_r[NF-1] || !q_full;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NF-2:0], in_valid};
    end
  end

  assign o_v[0] = in_data.origin_x;
  assign o_v[1] = in_data.origin_y;
  assign o_v[2] = in_data.origin_z;
  assign d_v[0] = in_data.dir_x;
  assign d_v[1] = in_data.dir_y;
  assign d_v[2] = in_data.dir_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m_od[i] = 64'(o_v[i]) * 64'(d_v[i]);
      m_oo[i] = 64'(o_v[i]) * 64'(o_v[i]);
    end
  end

  // floored Q16.16 products summed, then saturated
  assign bsum = 64'(pb1_r[0]) + 64'(pb1_r[1]) + 64'(pb1_r[2]);
  assign csum = 64'(pc1_r[0]) + 64'(pc1_r[1]) + 64'(pc1_r[2]) - 64'sd65536;
  assign disc = 64'(b2_r) * 64'(b2_r) - (64'(c2_r) <<< 16);

  always_ff @(posedge clk) begin
    if (adv) begin
      pay1_r <= in_data;
      for (int i = 0; i < 3; i++) begin
        pb1_r[i] <= m_od[i][63:16];
        pc1_r[i] <= m_oo[i][63:16];
      end
      pay2_r <= pay1_r;
      b2_r   <= sat32(bsum);
      c2_r   <= sat32(csum);
      side3_r.func <= pay2_r.func;
      side3_r.neg  <= disc[63];
      side3_r.b    <= b2_r;
      side3_r.o_x  <= pay2_r.origin_x;
      side3_r.o_y  <= pay2_r.origin_y;
      side3_r.o_z  <= pay2_r.origin_z;
      side3_r.d_x  <= pay2_r.dir_x;
      side3_r.d_y  <= pay2_r.dir_y;
      side3_r.d_z  <= pay2_r.dir_z;
      side3_r.lo   <= pay2_r.span_low;
      side3_r.hi   <= pay2_r.span_high;
      disc3_r      <= disc;
    end
  end

  rusi_sqrt #(
    .W  (SQ_WIDE),
    .SW ($bits(fside_t))
  ) u_sqrt (
    .clk      (clk),
    .en       (adv),
    .rad_in   (disc3_r),
    .side_in  (side3_r),
    .root_out (s_root),
    .side_out (s_side)
  );

  assign nb    = -64'(s_side.b);
  assign s64   = $signed({32'b0, s_root});
  assign t_sel = sat32(s_side.func ? (nb + s64) : (nb - s64));

  always_ff @(posedge clk) begin
    if (adv) begin
      push_r.hit <= !s_side.neg && (t_sel >= s_side.lo) && (t_sel <= s_side.hi);
      push_r.t   <= t_sel;
      push_r.o_x <= s_side.o_x;
      push_r.o_y <= s_side.o_y;
      push_r.o_z <= s_side.o_z;
      push_r.d_x <= s_side.d_x;
      push_r.d_y <= s_side.d_y;
      push_r.d_z <= s_side.d_z;
    end
  end

  assign push_valid = vld_r[NF-1];
  assign push_data  = push_r;

endmodule

@@ rtl/core/rusi_back.sv @@
// Back part: hit point, length, normal (divide) and spherical uv (CORDIC).
// Uses rusi_pkg, rusi_sqrt, rusi_div and rusi_cordic.
module rusi_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  rusi_pkg::queue_item_t q_data,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output rusi_pkg::out_item_t   out_data
);
  import rusi_pkg::*;

  localparam int SQL_LAT = SQ_WIDE / 2;
  localparam int SQV_LAT = SQ_NARROW / 2;
  localparam int COR_LAT = CORDIC_STEPS + 1;
  localparam int NB      = 4 + SQL_LAT + DIV_NUM + 1;
  localparam int U_DLY   = SQL_LAT + DIV_NUM - COR_LAT;
  localparam int V_DLY   = SQL_LAT + DIV_NUM - SQV_LAT - COR_LAT;
  localparam logic [SQ_NARROW-1:0] ONE_SQ = SQ_NARROW'(64'h1_0000_0000);

  typedef struct packed {
    logic              hit;
    logic signed [31:0] t;
    logic signed [31:0] p_x;
    logic signed [31:0] p_y;
    logic signed [31:0] p_z;
  } bside_t;

  typedef struct packed {
    logic              hit;
    logic              zl;
    logic signed [31:0] t;
    logic signed [31:0] p_x;
    logic signed [31:0] p_y;
    logic signed [31:0] p_z;
  } dside_t;

  logic [NB-1:0] vld_r;
  logic          adv;

  logic signed [31:0] d_v [3];
  logic signed [63:0] tdm [3];
  queue_item_t        q1_r;
  logic signed [47:0] tp1_r [3];
  logic signed [31:0] o1_v [3];

  logic               hit2_r;
  logic signed [31:0] t2_r;
  logic signed [31:0] p2_r [3];

  logic               hit3_r;
  logic signed [31:0] t3_r;
  logic signed [31:0] p3_r [3];
  logic [63:0]        sq3_r [3];
  logic signed [17:0] zc3_r;
  logic [32:0]        zsq3_r;
  logic signed [17:0] zc;
  logic signed [35:0] zsq;
  logic signed [63:0] psq [3];

  bside_t             s4_r;
  logic [63:0]        len2_r;
  logic signed [17:0] zc4_r;
  logic [SQ_NARROW-1:0] vrad4_r;

  logic [SQL_LAT-1:0] len;
  bside_t             l_side;
  dside_t             d_side_in;
  dside_t             d_side;
  logic [2:0][DIV_NUM-1:0] num;
  logic [2:0][DIV_NUM-1:0] quo;
  logic signed [31:0] lp [3];
  logic signed [31:0] dp [3];
  logic signed [31:0] nrm [3];

  logic [SQV_LAT-1:0] vroot;
  logic [17:0]        vzc;
  logic signed [ZW-1:0] u_z;
  logic signed [ZW-1:0] v_z;
  logic signed [ZW-1:0] u_dly_r [U_DLY];
  logic signed [ZW-1:0] v_dly_r [V_DLY];
  out_item_t          fin;
  out_item_t          out_r;

  assign adv   = !vld_r[NB-1] || out_ready;
  assign q_pop = q_valid && adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NB-2:0], q_valid};
    end
  end

  assign d_v[0] = q_data.d_x;
  assign d_v[1] = q_data.d_y;
  assign d_v[2] = q_data.d_z;
  assign o1_v[0] = q1_r.o_x;
  assign o1_v[1] = q1_r.o_y;
  assign o1_v[2] = q1_r.o_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tdm[i] = 64'(q_data.t) * 64'(d_v[i]);
      psq[i] = 64'(p2_r[i]) * 64'(p2_r[i]);
    end
  end

  // z clamped to [-1, 1] for the acos path
  always_comb begin
    if (p2_r[2] > 32'sd65536) begin
      zc = 18'sd65536;
    end else if (p2_r[2] < -32'sd65536) begin
      zc = -18'sd65536;
    end else begin
      zc = p2_r[2][17:0];
    end
    zsq = 36'(zc) * 36'(zc);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q1_r <= q_data;
      for (int i = 0; i < 3; i++) begin
        tp1_r[i] <= tdm[i][63:16];
        p2_r[i]  <= sat32(64'(o1_v[i]) + 64'(tp1_r[i]));
        p3_r[i]  <= p2_r[i];
        sq3_r[i] <= psq[i];
      end
      hit2_r  <= q1_r.hit;
      t2_r    <= q1_r.t;
      hit3_r  <= hit2_r;
      t3_r    <= t2_r;
      zc3_r   <= zc;
      zsq3_r  <= zsq[32:0];
      s4_r.hit <= hit3_r;
      s4_r.t   <= t3_r;
      s4_r.p_x <= p3_r[0];
      s4_r.p_y <= p3_r[1];
      s4_r.p_z <= p3_r[2];
      len2_r   <= sq3_r[0] + sq3_r[1] + sq3_r[2];
      zc4_r    <= zc3_r;
      vrad4_r  <= ONE_SQ - SQ_NARROW'(zsq3_r);
    end
  end

  rusi_sqrt #(
    .W  (SQ_WIDE),
    .SW ($bits(bside_t))
  ) u_sqrt_len (
    .clk      (clk),
    .en       (adv),
    .rad_in   (len2_r),
    .side_in  (s4_r),
    .root_out (len),
    .side_out (l_side)
  );

  assign lp[0] = l_side.p_x;
  assign lp[1] = l_side.p_y;
  assign lp[2] = l_side.p_z;

  always_comb begin
    logic [31:0] mag;
    for (int i = 0; i < 3; i++) begin
      mag    = lp[i][31] ? 32'(-lp[i]) : lp[i];
      num[i] = {mag, 16'b0};
    end
    d_side_in.hit = l_side.hit;
    d_side_in.zl  = (len == '0);
    d_side_in.t   = l_side.t;
    d_side_in.p_x = l_side.p_x;
    d_side_in.p_y = l_side.p_y;
    d_side_in.p_z = l_side.p_z;
  end

  rusi_div #(
    .NW    (DIV_NUM),
    .DW    (DIV_DEN),
    .LANES (3),
    .SW    ($bits(dside_t))
  ) u_div (
    .clk      (clk),
    .en       (adv),
    .num_in   (num),
    .den_in   (len),
    .side_in  (d_side_in),
    .quo_out  (quo),
    .side_out (d_side)
  );

  rusi_cordic u_cordic_u (
    .clk   (clk),
    .en    (adv),
    .yy    (s4_r.p_x),
    .xx    (s4_r.p_y),
    .z_out (u_z)
  );

  rusi_sqrt #(
    .W  (SQ_NARROW),
    .SW (18)
  ) u_sqrt_v (
    .clk      (clk),
    .en       (adv),
    .rad_in   (vrad4_r),
    .side_in  (zc4_r),
    .root_out (vroot),
    .side_out (vzc)
  );

  rusi_cordic u_cordic_v (
    .clk   (clk),
    .en    (adv),
    .yy    ($signed(32'(vroot))),
    .xx    (32'($signed(vzc))),
    .z_out (v_z)
  );

  // line the angles up with the divider output
  always_ff @(posedge clk) begin
    if (adv) begin
      u_dly_r[0] <= u_z;
      for (int k = 1; k < U_DLY; k++) begin
        u_dly_r[k] <= u_dly_r[k-1];
      end
      v_dly_r[0] <= v_z;
      for (int k = 1; k < V_DLY; k++) begin
        v_dly_r[k] <= v_dly_r[k-1];
      end
    end
  end

  assign dp[0] = d_side.p_x;
  assign dp[1] = d_side.p_y;
  assign dp[2] = d_side.p_z;

  always_comb begin
    logic [31:0] ql;
    for (int i = 0; i < 3; i++) begin
      ql = quo[i][31:0];
      if (d_side.zl) begin
        nrm[i] = '0;
      end else if (dp[i][31]) begin
        nrm[i] = $signed(-ql);
      end else begin
        nrm[i] = $signed(ql);
      end
    end
    fin.hit      = 1'b1;
    fin.t_param  = d_side.t;
    fin.point_x  = d_side.p_x;
    fin.point_y  = d_side.p_y;
    fin.point_z  = d_side.p_z;
    fin.normal_x = nrm[0];
    fin.normal_y = nrm[1];
    fin.normal_z = nrm[2];
    fin.tex_u    = 32'(u_dly_r[U_DLY-1]);
    fin.tex_v    = 32'(v_dly_r[V_DLY-1]);
    if (!d_side.hit) begin
      fin = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= fin;
    end
  end

  assign out_valid = vld_r[NB-1];
  assign out_data  = out_r;

endmodule

@@ tb/ray_unit_sphere_intersect_core_tb.sv @@
// Testbench for ray_unit_sphere_intersect_core: random and directed rays against a
// cycle-free Q16.16 predictor, checked field by field in order. Depends on rusi_pkg.
module ray_unit_sphere_intersect_core_tb;
  import rusi_pkg::*;

  localparam int LATENCY   = 121;
  localparam int STALL_MAX = 20000;
  localparam int FRAC      = 65536;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;

  ray_unit_sphere_intersect_core dut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  in_item_t  ray_queue[$];
  out_item_t hit_queue[$];
  int send_idle_pct = 18;
  int recv_idle_pct = 57;
  int errors = 0;
  int quiet_cycles = 0;
  bit stim_done = 1'b0;
  bit in_taken = 1'b0;

  function automatic longint fdiv16(longint v);
    return (v >= 0) ? (v >>> 16) : -((-(v + 1)) >>> 16) - 1;
  endfunction

  function automatic longint fdivn(longint v, int n);
    return (v >= 0) ? (v >>> n) : -((-(v + 1)) >>> n) - 1;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic longint angle_of(longint yy, longint xx);
    longint x, y, z, dx, dy;
    longint atab[17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                         256, 128, 64, 32, 16, 8, 4, 2, 1};
    x = xx; y = yy; z = 0;
    if (xx == 0 && yy == 0) return 0;
    if (xx < 0) begin
      x = -xx; y = -yy;
      z = (yy >= 0) ? 205887 : -205887;
    end
    for (int i = 0; i < 17; i++) begin
      dx = fdivn(y, i);
      dy = fdivn(x, i);
      if (y > 0) begin
        x += dx; y -= dy; z += atab[i];
      end else begin
        x -= dx; y += dy; z -= atab[i];
      end
    end
    return z;
  endfunction

  function automatic out_item_t predict_hit(in_item_t r);
    out_item_t res;
    longint o[3], d[3], p[3];
    longint b, c, disc, s, t, zc;
    longint unsigned len2, len;
    res = '0;
    o[0] = r.origin_x; o[1] = r.origin_y; o[2] = r.origin_z;
    d[0] = r.dir_x; d[1] = r.dir_y; d[2] = r.dir_z;
    b = 0; c = 0;
    for (int i = 0; i < 3; i++) begin
      b += fdiv16(o[i] * d[i]);
      c += fdiv16(o[i] * o[i]);
    end
    b = clamp32(b);
    c = clamp32(c - FRAC);
    disc = b * b - c * FRAC;
    if (disc < 0) return res;
    s = longint'(int_sqrt(longint'(disc)));
    t = clamp32(r.func ? (-b + s) : (-b - s));
    if (t < longint'(r.span_low) || t > longint'(r.span_high)) return res;
    len2 = 0;
    for (int i = 0; i < 3; i++) begin
      p[i] = clamp32(o[i] + fdiv16(t * d[i]));
      len2 += longint'(p[i] * p[i]);
    end
    len = int_sqrt(len2);
    res.hit = 1'b1;
    res.t_param = t[31:0];
    res.point_x = p[0][31:0];
    res.point_y = p[1][31:0];
    res.point_z = p[2][31:0];
    if (len != 0) begin
      res.normal_x = 32'((p[0] * FRAC) / longint'(len));
      res.normal_y = 32'((p[1] * FRAC) / longint'(len));
      res.normal_z = 32'((p[2] * FRAC) / longint'(len));
    end
    res.tex_u = 32'(clamp32(angle_of(p[0], p[1])));
    zc = p[2];
    if (zc > FRAC) zc = FRAC;
    if (zc < -FRAC) zc = -FRAC;
    res.tex_v = 32'(clamp32(angle_of(longint'(int_sqrt(longint'(64'sd4294967296 - zc * zc))),
                                     zc)));
    return res;
  endfunction

  // driver: inputs change on the falling edge; in_taken marks the last rising-edge accept
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_taken) begin
        if (ray_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data <= ray_queue.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor: sample at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      in_taken <= in_valid && in_ready;
      if (in_valid && in_ready) hit_queue.push_back(predict_hit(in_data));
      if (out_valid && out_ready) begin
        if (hit_queue.size() == 0) begin
          $display("%0t: unexpected result %p", $time, out_data);
          errors++;
        end else begin
          out_item_t want;
          want = hit_queue.pop_front();
          if (want.hit != out_data.hit) begin
            $display("%0t: hit exp %0d got %0d", $time, want.hit, out_data.hit); errors++;
          end
          if (want.t_param != out_data.t_param) begin
            $display("%0t: t_param exp %0d got %0d", $time, want.t_param, out_data.t_param);
            errors++;
          end
          if (want.point_x != out_data.point_x) begin
            $display("%0t: point_x exp %0d got %0d", $time, want.point_x, out_data.point_x);
            errors++;
          end
          if (want.point_y != out_data.point_y) begin
            $display("%0t: point_y exp %0d got %0d", $time, want.point_y, out_data.point_y);
            errors++;
          end
          if (want.point_z != out_data.point_z) begin
            $display("%0t: point_z exp %0d got %0d", $time, want.point_z, out_data.point_z);
            errors++;
          end
          if (want.normal_x != out_data.normal_x) begin
            $display("%0t: normal_x exp %0d got %0d", $time, want.normal_x,
                     out_data.normal_x);
            errors++;
          end
          if (want.normal_y != out_data.normal_y) begin
            $display("%0t: normal_y exp %0d got %0d", $time, want.normal_y,
                     out_data.normal_y);
            errors++;
          end
          if (want.normal_z != out_data.normal_z) begin
            $display("%0t: normal_z exp %0d got %0d", $time, want.normal_z,
                     out_data.normal_z);
            errors++;
          end
          if (want.tex_u != out_data.tex_u) begin
            $display("%0t: tex_u exp %0d got %0d", $time, want.tex_u, out_data.tex_u);
            errors++;
          end
          if (want.tex_v != out_data.tex_v) begin
            $display("%0t: tex_v exp %0d got %0d", $time, want.tex_v, out_data.tex_v);
            errors++;
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) ||
          (stim_done && hit_queue.size() == 0)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_MAX) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  function automatic logic signed [31:0] rand_q(int mode);
    // mode 0: anywhere; 1: within about +-4.0; 2: within about +-1.0
    case (mode)
      0: return $signed($urandom);
      1: return $signed(32'($urandom_range(524288) - 262144));
      default: return $signed(32'($urandom_range(131072) - 65536));
    endcase
  endfunction

  function automatic in_item_t make_ray(bit func, int ox, int oy, int oz,
                                        int dx, int dy, int dz, int lo, int hi);
    in_item_t r;
    r.func = func;
    r.origin_x = ox; r.origin_y = oy; r.origin_z = oz;
    r.dir_x = dx; r.dir_y = dy; r.dir_z = dz;
    r.span_low = lo; r.span_high = hi;
    return r;
  endfunction

  task automatic push_random(int n);
    in_item_t r;
    int sel;
    longint len;
    for (int k = 0; k < n; k++) begin
      sel = $urandom_range(9);
      r.func = $urandom_range(1);
      if (sel < 7) begin
        // well-formed ray: origin near the sphere, roughly unit direction
        r.origin_x = rand_q(1); r.origin_y = rand_q(1); r.origin_z = rand_q(1);
        r.dir_x = rand_q(2); r.dir_y = rand_q(2); r.dir_z = rand_q(2);
        len = int_sqrt(longint'(r.dir_x) * r.dir_x + longint'(r.dir_y) * r.dir_y +
                       longint'(r.dir_z) * r.dir_z);
        if (len != 0) begin
          r.dir_x = 32'((longint'(r.dir_x) * FRAC) / len);
          r.dir_y = 32'((longint'(r.dir_y) * FRAC) / len);
          r.dir_z = 32'((longint'(r.dir_z) * FRAC) / len);
        end
        r.span_low = (sel < 5) ? -32'sd2147483648 : rand_q(1);
        r.span_high = (sel < 5) ? 32'sd2147483647 : rand_q(1);
      end else begin
        r.origin_x = rand_q(0); r.origin_y = rand_q(0); r.origin_z = rand_q(0);
        r.dir_x = rand_q(0); r.dir_y = rand_q(0); r.dir_z = rand_q(0);
        r.span_low = rand_q(0); r.span_high = rand_q(0);
      end
      ray_queue.push_back(r);
    end
  endtask

  task automatic drain();
    while (ray_queue.size() != 0 || in_valid || hit_queue.size() != 0) @(posedge clk);
  endtask

  localparam int ONE = 65536;
  localparam int MAXQ = 32'h7fffffff;
  localparam int MINQ = 32'h80000000;

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    // directed: both roots, tangent, miss, empty span, extremes, zero point, inside
    ray_queue.push_back(make_ray(0, 0, 0, -2 * ONE, 0, 0, ONE, MINQ, MAXQ));
    ray_queue.push_back(make_ray(1, 0, 0, -2 * ONE, 0, 0, ONE, MINQ, MAXQ));
    ray_queue.push_back(make_ray(0, ONE, -3 * ONE, 0, 0, ONE, 0, MINQ, MAXQ));
    ray_queue.push_back(make_ray(0, 2 * ONE, 0, -2 * ONE, 0, 0, ONE, MINQ, MAXQ));
    ray_queue.push_back(make_ray(1, 0, 0, -2 * ONE, 0, 0, ONE, 5 * ONE, ONE));
    ray_queue.push_back(make_ray(0, 0, 0, -2 * ONE, 0, 0, ONE, ONE, ONE));
    ray_queue.push_back(make_ray(0, 0, 0, -2 * ONE, 0, 0, ONE, ONE + 1, MAXQ));
    ray_queue.push_back(make_ray(0, 0, 0, 0, ONE, 0, 0, MINQ, MAXQ));
    ray_queue.push_back(make_ray(1, 0, 0, 0, 0, -ONE, 0, MINQ, MAXQ));
    ray_queue.push_back(make_ray(0, MAXQ, MAXQ, MAXQ, MAXQ, MAXQ, MAXQ, MINQ, MAXQ));
    ray_queue.push_back(make_ray(1, MINQ, MINQ, MINQ, MINQ, MINQ, MINQ, MINQ, MAXQ));
    ray_queue.push_back(make_ray(1, MINQ, MAXQ, MINQ, MAXQ, MINQ, MAXQ, MINQ, MAXQ));
    ray_queue.push_back(make_ray(0, -1, -1, -1, -1, -1, -1, -1, -1));
    ray_queue.push_back(make_ray(1, 0, 0, 0, 0, 0, 0, MINQ, MAXQ));
    ray_queue.push_back(make_ray(0, 0, 0, 0, 0, 0, 0, MINQ, MAXQ));
    ray_queue.push_back(make_ray(1, 0, 0, 0, 2 * ONE, 0, 0, MINQ, MAXQ));
    ray_queue.push_back(make_ray(0, 0, 0, 3 * ONE, 0, 0, -2 * ONE, MINQ, MAXQ));
    push_random(170);
    drain();
    send_idle_pct = 57;
    recv_idle_pct = 18;
    push_random(170);
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    push_random(160);
    drain();
    stim_done = 1'b1;
    repeat (2 * LATENCY) @(posedge clk);
    if (errors == 0 && hit_queue.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

@@ ray_unit_sphere_intersect_core.f @@
rtl/core/rusi_pkg.sv
rtl/core/rusi_sqrt.sv
rtl/core/rusi_div.sv
rtl/core/rusi_cordic.sv
rtl/core/rusi_front.sv
rtl/core/rusi_back.sv
rtl/core/ray_unit_sphere_intersect_core.sv
tb/ray_unit_sphere_intersect_core_tb.sv
